[rtl/ssfd_pkg.sv]
// Package for the seven-segment frame driver: codes, tables and font lookup.
`default_nettype none
package ssfd_pkg;

  localparam int NUM_DIGITS   = 12;
  localparam int FRAME_BYTES  = 16;
  localparam int MEM_DEPTH    = 16;
  localparam int TABLE_DIGITS = 12;
  localparam int SEGMENTS     = 7;

  localparam logic [7:0] CMD_DATA = 8'h40;
  localparam logic [7:0] CMD_ADDR = 8'hc0;
  localparam logic [7:0] CMD_OFF  = 8'h80;
  localparam logic [7:0] CMD_ON   = 8'h88;

  localparam logic [2:0] OP_SET_CHAR    = 3'd0;
  localparam logic [2:0] OP_SET_RAW     = 3'd1;
  localparam logic [2:0] OP_CLEAR       = 3'd2;
  localparam logic [2:0] OP_FLUSH       = 3'd3;
  localparam logic [2:0] OP_DISPLAY_CTL = 3'd4;

  localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [1:0] REG_ENABLE     = 2'd1;

  localparam logic [6:0] HEX_GLYPH [16] = '{
    7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07,
    7'h7f, 7'h6f, 7'h77, 7'h7c, 7'h39, 7'h5e, 7'h79, 7'h71
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG,
    ST_DATA,
    ST_ADDR,
    ST_MEM,
    ST_DISP
  } state_t;

  typedef struct packed {
    logic       known;
    logic [6:0] pattern;
  } glyph_t;

  // Controller bit that a logical digit drives; digits past the table map to 0.
  function automatic logic [3:0] digit_bit(input logic [3:0] d);
    logic [3:0] b;
    case (d)
      4'd10:   b = 4'd12;
      4'd11:   b = 4'd13;
      default: b = (d < 4'd10) ? d : 4'd0;
    endcase
    return b;
  endfunction

  function automatic glyph_t hex_decode(input logic [7:0] c);
    glyph_t g;
    logic [7:0] k;
    g.known   = 1'b1;
    g.pattern = 7'h00;
    k         = 8'h00;
    case (c) inside
      [8'h30:8'h39]: begin
        k = c - 8'h30;
        g.pattern = HEX_GLYPH[k[3:0]];
      end
      [8'h41:8'h46]: begin
        k = c - 8'h37;
        g.pattern = HEX_GLYPH[k[3:0]];
      end
      [8'h61:8'h66]: begin
        k = c - 8'h57;
        g.pattern = HEX_GLYPH[k[3:0]];
      end
      8'h20: g.pattern = 7'h00;
      default: g.known = 1'b0;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

[rtl/seven_segment_frame_driver.sv]
// Top level of the seven-segment frame driver: display memory copy and byte sequencer.
`default_nettype none
// Command-style host side of a 16-byte LED controller. An item transfers at a
// rising edge with start high and busy low; each output byte is shown for one
// cycle with result_valid high and cannot be held off. set_char and set_raw
// keep busy high while the seven segment bytes are read and written back
// through the display memory, a read issued in one cycle and the modified
// byte written in the next, overlapped across segments. flush and clear
// keep busy high while they give 19 bytes, one per cycle, limited by the
// single read port of the memory; display_control gives one byte, registered
// out of the display state that follows its transfer. Unknown characters,
// out-of-range digits and unused operation codes are dropped with no busy
// time. The memory comes up cleared through per-entry valid bits, so there
// is no clearing pass, and clear wipes those bits in the cycle it transfers.
module seven_segment_frame_driver (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] operation,
  input  wire logic [3:0] digit_index,
  input  wire logic [7:0] char_code,
  input  wire logic [7:0] segment_bits,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [2:0] cfg_data,
  output logic            result_valid,
  output logic [7:0]      out_byte,
  output logic            strobe_begin,
  output logic            strobe_end,
  output logic            last
);
  import ssfd_pkg::*;

  // Configuration registers.
  logic [2:0] brightness_level;
  logic       display_enable;

  // Sequencer state.
  state_t     state, state_next;
  logic [3:0] step, step_next;

  // Latched segment update.
  logic [6:0] pattern;
  logic       offset;
  logic [7:0] mask;

  // Display memory with valid bits that stand for the cleared reset value.
  logic [7:0]            mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]  valid;
  logic [7:0]            mem_q;
  logic                  mem_q_ok;
  logic [7:0]            rd_data;

  logic       rd_en, wr_en;
  logic [3:0] rd_addr, wr_addr;
  logic [7:0] wr_data;

  logic       res_valid_next, res_sb_next, res_se_next, res_last_next;
  logic [7:0] res_byte_next;

  logic       accept;
  glyph_t     glyph;
  logic       digit_ok;
  logic [3:0] dbit;
  logic [2:0] seg_prev;
  logic [7:0] disp_cmd;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign glyph   = hex_decode(char_code);
  assign dbit    = digit_bit(digit_index);
  assign digit_ok = ({1'b0, digit_index} < 5'(NUM_DIGITS)) &&
                    ({1'b0, digit_index} < 5'(TABLE_DIGITS));
  assign rd_data  = mem_q_ok ? mem_q : 8'h00;
  assign seg_prev = step[2:0] - 3'd1;
  assign disp_cmd = display_enable ? (CMD_ON | {5'b0, brightness_level}) : CMD_OFF;

  // Next state.
  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_IDLE: begin
        step_next = 4'd0;
        if (accept) begin
          case (operation)
            OP_SET_CHAR:    if (glyph.known && digit_ok) state_next = ST_SEG;
            OP_SET_RAW:     if (digit_ok) state_next = ST_SEG;
            OP_CLEAR,
            OP_FLUSH:       state_next = ST_DATA;
            OP_DISPLAY_CTL: state_next = ST_DISP;
            default:        state_next = ST_IDLE;
          endcase
        end
      end
      ST_SEG: begin
        step_next = step + 4'd1;
        if (step[2:0] == 3'(SEGMENTS)) state_next = ST_IDLE;
      end
      ST_DATA: state_next = ST_ADDR;
      ST_ADDR: begin
        step_next  = 4'd0;
        state_next = ST_MEM;
      end
      ST_MEM: begin
        step_next = step + 4'd1;
        if (step == 4'(FRAME_BYTES - 1)) state_next = ST_DISP;
      end
      ST_DISP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: memory port controls and next result byte.
  always_comb begin
    rd_en          = 1'b0;
    rd_addr        = 4'd0;
    wr_en          = 1'b0;
    wr_addr        = {seg_prev, offset};
    wr_data        = pattern[seg_prev] ? (rd_data | mask) : (rd_data & ~mask);
    res_valid_next = 1'b0;
    res_byte_next  = 8'h00;
    res_sb_next    = 1'b0;
    res_se_next    = 1'b0;
    res_last_next  = 1'b0;
    case (state)
      ST_SEG: begin
        // Read segment step while writing back segment step-1.
        rd_en   = (step[2:0] != 3'(SEGMENTS));
        rd_addr = {step[2:0], offset};
        wr_en   = (step[2:0] != 3'd0);
      end
      ST_DATA: begin
        res_valid_next = 1'b1;
        res_byte_next  = CMD_DATA;
        res_sb_next    = 1'b1;
        res_se_next    = 1'b1;
      end
      ST_ADDR: begin
        rd_en          = 1'b1;
        rd_addr        = 4'd0;
        res_valid_next = 1'b1;
        res_byte_next  = CMD_ADDR;
        res_sb_next    = 1'b1;
      end
      ST_MEM: begin
        rd_en          = 1'b1;
        rd_addr        = step + 4'd1;
        res_valid_next = 1'b1;
        res_byte_next  = rd_data;
        res_se_next    = (step == 4'(FRAME_BYTES - 1));
      end
      ST_DISP: begin
        res_valid_next = 1'b1;
        res_byte_next  = disp_cmd;
        res_sb_next    = 1'b1;
        res_se_next    = 1'b1;
        res_last_next  = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      step             <= 4'd0;
      result_valid     <= 1'b0;
      brightness_level <= 3'd7;
      display_enable   <= 1'b1;
      valid            <= '0;
    end else begin
      state        <= state_next;
      step         <= step_next;
      result_valid <= res_valid_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_BRIGHTNESS: brightness_level <= cfg_data;
          REG_ENABLE:     display_enable   <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept && operation == OP_CLEAR) begin
        valid <= '0;
      end else if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_byte     <= res_byte_next;
    strobe_begin <= res_sb_next;
    strobe_end   <= res_se_next;
    last         <= res_last_next;
    if (accept) begin
      // Hold the decoded update for the read-modify-write pass.
      pattern <= (operation == OP_SET_CHAR) ? glyph.pattern : segment_bits[6:0];
      offset  <= dbit[3];
      mask    <= 8'h01 << dbit[2:0];
    end
  end

  // Display memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      mem_q_ok <= valid[rd_addr];
    end
  end

`ifndef ASSERT_OFF
  a_no_same_entry: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same memory entry");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |-> !busy)
    else $error("busy still high after the final byte");

  a_flush_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && (operation == OP_FLUSH || operation == OP_CLEAR)) |=> ##1
      (result_valid && out_byte == CMD_DATA && strobe_begin && strobe_end))
    else $error("flush did not open with the data command");

  a_seg_silent: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEG) |=> !result_valid)
    else $error("segment update produced an output byte");
`endif

endmodule
`default_nettype wire

[tb/seven_segment_frame_driver_test.sv]
// Self-checking testbench for seven_segment_frame_driver: memory updates, flush runs, config.
`timescale 1ns / 100ps
module seven_segment_frame_driver_test;
  import ssfd_pkg::*;

  // Register indexes past the two real ones; writes there must change nothing.
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  localparam int CYCLE_LIMIT = 200000;
  // set_char / set_raw keep the block busy with no byte out,
  // so hold this long after the last byte before touching the registers.
  localparam int IDLE_PAUSE  = 16;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 74;

  // Register settings walked through after the reset setting; the enable data
  // carries junk in its upper bits, which the block must drop.
  localparam logic [2:0] BRIGHT_SET [PHASES] = '{3'd0, 3'd7, 3'd3, 3'd5, 3'd1, 3'd7};
  localparam logic [2:0] ENABLE_SET [PHASES] = '{3'b001, 3'b000, 3'b111, 3'b110, 3'b101, 3'b001};

  // Hex font, segment A in bit 0.
  localparam logic [6:0] FONT [16] = '{
    7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07,
    7'h7f, 7'h6f, 7'h77, 7'h7c, 7'h39, 7'h5e, 7'h79, 7'h71
  };
  // Controller bit driven by each logical digit.
  localparam logic [3:0] DIGIT_BIT [12] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd12, 4'd13
  };

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] digit;
    logic [7:0] ch;
    logic [7:0] raw;
  } command_t;

  typedef struct packed {
    logic [7:0] data;
    logic       sb;
    logic       se;
    logic       lst;
  } bus_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [2:0] operation = '0;
  logic [3:0] digit_index = '0;
  logic [7:0] char_code = '0;
  logic [7:0] segment_bits = '0;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [2:0] cfg_data = '0;
  logic       busy;
  logic       result_valid;
  logic [7:0] out_byte;
  logic       strobe_begin;
  logic       strobe_end;
  logic       last;

  seven_segment_frame_driver dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .digit_index  (digit_index),
    .char_code    (char_code),
    .segment_bits (segment_bits),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .out_byte     (out_byte),
    .strobe_begin (strobe_begin),
    .strobe_end   (strobe_end),
    .last         (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Commands waiting to be driven, and bus bytes the block still owes us.
  command_t  pending_cmds[$];
  bus_byte_t owed_bytes[$];

  // Shadow of the block: display memory and the two registers.
  logic [7:0] shadow_mem [MEM_DEPTH];
  logic [2:0] shadow_bright = 3'd7;
  logic       shadow_enable = 1'b1;

  int mismatches = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  string glyph_chars = "0123456789ABCDEFabcdef ";

  initial begin
    shadow_mem = '{default: 8'h00};
  end

  function automatic command_t mk_cmd(logic [2:0] op, logic [3:0] digit,
                                      logic [7:0] ch, logic [7:0] raw);
    command_t c;
    c.op = op;
    c.digit = digit;
    c.ch = ch;
    c.raw = raw;
    return c;
  endfunction

  function automatic logic [7:0] display_cmd();
    return shadow_enable ? (CMD_ON | {5'b0, shadow_bright}) : CMD_OFF;
  endfunction

  // Spread one digit's segments over the even (bits 0-7) or odd (bits 8+) addresses.
  function automatic void store_pattern(logic [3:0] digit, logic [6:0] pattern);
    logic [3:0] bitpos;
    logic [7:0] mask;
    logic [2:0] seg;
    logic [3:0] addr;
    if (digit >= NUM_DIGITS || digit >= TABLE_DIGITS) return;
    bitpos = DIGIT_BIT[digit];
    mask = 8'd1 << bitpos[2:0];
    for (int s = 0; s < SEGMENTS; s++) begin
      seg = 3'(s);
      addr = {seg, bitpos[3]};
      if (pattern[seg]) shadow_mem[addr] = shadow_mem[addr] | mask;
      else shadow_mem[addr] = shadow_mem[addr] & ~mask;
    end
  endfunction

  // Data command, address command plus the whole memory, display command.
  function automatic void owe_memory_dump();
    logic [3:0] a;
    owed_bytes.push_back('{CMD_DATA, 1'b1, 1'b1, 1'b0});
    owed_bytes.push_back('{CMD_ADDR, 1'b1, 1'b0, 1'b0});
    for (int i = 0; i < FRAME_BYTES; i++) begin
      a = 4'(i);
      owed_bytes.push_back('{shadow_mem[a], 1'b0, (i == FRAME_BYTES - 1), 1'b0});
    end
    owed_bytes.push_back('{display_cmd(), 1'b1, 1'b1, 1'b1});
  endfunction

  // Advance the shadow by one accepted command and queue the bytes it owes.
  function automatic void apply_command(command_t c);
    logic [7:0] ch;
    logic [7:0] k;
    ch = c.ch;
    k = 8'h00;
    case (c.op)
      OP_SET_CHAR: begin
        // Anything outside the hex digits and space is dropped.
        if (ch >= "0" && ch <= "9") begin
          k = ch - 8'h30;
          store_pattern(c.digit, FONT[k[3:0]]);
        end else if (ch >= "A" && ch <= "F") begin
          k = ch - 8'h37;
          store_pattern(c.digit, FONT[k[3:0]]);
        end else if (ch >= "a" && ch <= "f") begin
          k = ch - 8'h57;
          store_pattern(c.digit, FONT[k[3:0]]);
        end else if (ch == " ") store_pattern(c.digit, 7'h00);
      end
      OP_SET_RAW: store_pattern(c.digit, c.raw[6:0]);
      OP_CLEAR: begin
        shadow_mem = '{default: 8'h00};
        owe_memory_dump();
      end
      OP_FLUSH: owe_memory_dump();
      OP_DISPLAY_CTL: owed_bytes.push_back('{display_cmd(), 1'b1, 1'b1, 1'b1});
      default: ;  // unused codes do nothing
    endcase
  endfunction

  task automatic flag_mismatch(string what, bus_byte_t want, bus_byte_t seen);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected %02h sb %b se %b last %b, got %02h sb %b se %b last %b",
               $realtime, what, want.data, want.sb, want.se, want.lst,
               seen.data, seen.sb, seen.se, seen.lst);
  endtask

  // Driver: present the next command once the previous one has transferred.
  // Commands go out in bursts of random length; the gaps between bursts land
  // anywhere in the block's busy time since they start right after a transfer.
  always @(posedge clk) begin : driver
    command_t c;
    if (rst) begin
      start <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!start || !busy) begin
      if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() != 0) begin
        c = pending_cmds.pop_front();
        operation <= c.op;
        digit_index <= c.digit;
        char_code <= c.ch;
        segment_bits <= c.raw;
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 4);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check each strobed byte against the oldest owed one, then track
  // register writes and command transfers at the same edge.
  always @(posedge clk) begin : monitor
    bus_byte_t seen;
    bus_byte_t want;
    if (!rst) begin
      if (result_valid) begin
        seen = '{out_byte, strobe_begin, strobe_end, last};
        if (owed_bytes.size() == 0) begin
          flag_mismatch("byte with nothing owed", '0, seen);
        end else begin
          want = owed_bytes.pop_front();
          if (seen !== want) flag_mismatch("bus byte mismatch", want, seen);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_BRIGHTNESS: shadow_bright = cfg_data;
          REG_ENABLE:     shadow_enable = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy)
        apply_command(mk_cmd(operation, digit_index, char_code, segment_bits));
    end
  end

  // Watchdog on a generous cycle budget.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("seven_segment_frame_driver test failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] index, logic [2:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Sample mid-cycle so the driver's updates of this edge are settled.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_cmds.size() != 0 || start || busy || owed_bytes.size() != 0)
      @(negedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  // Mostly well-formed updates and flushes, with a share of junk commands.
  // Every queued command counts toward the total.
  task automatic queue_random(int count);
    command_t c;
    int pick;
    for (int n = 0; n < count; n++) begin
      c = mk_cmd(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      pick = $urandom_range(0, 99);
      if (pick < 65 && $urandom_range(0, 9) != 0) c.digit = 4'($urandom_range(0, 11));
      if (pick < 35) begin
        c.op = OP_SET_CHAR;
        c.ch = glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
      end else if (pick < 45) c.op = OP_SET_CHAR;
      else if (pick < 65) c.op = OP_SET_RAW;
      else if (pick < 80) c.op = OP_FLUSH;
      else if (pick < 85) c.op = OP_CLEAR;
      else if (pick < 93) c.op = OP_DISPLAY_CTL;
      pending_cmds.push_back(c);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty memory, every operation, font edges, both digit halves,
    // dropped characters, out-of-range digits, segment bit 7, unused codes.
    pending_cmds.push_back(mk_cmd(OP_FLUSH, 4'd0, 8'h00, 8'h00));
    pending_cmds.push_back(mk_cmd(OP_DISPLAY_CTL, 4'd0, 8'h00, 8'h00));
    pending_cmds.push_back(mk_cmd(OP_SET_CHAR, 4'd0, "0", 8'h00));
    pending_cmds.push_back(mk_cmd(OP_SET_CHAR, 4'd11, "9", 8'hff));
    pending_cmds.push_back(mk_cmd(OP_SET_CHAR, 4'd10, "F", 8'h00));
    pending_cmds.push_back(mk_cmd(OP_SET_CHAR, 4'd1, "a", 8'h00));
    pending_cmds.push_back(mk_cmd(OP_SET_CHAR, 4'd2, "f", 8'h00));
    pending_cmds.push_back(mk_cmd(OP_SET_CHAR, 4'd3, "A", 8'h00));
    pending_cmds.push_back(mk_cmd(OP_SET_CHAR, 4'd8, "8", 8'h00));
    pending_cmds.push_back(mk_cmd(OP_SET_CHAR, 4'd3, " ", 8'h00));
    pending_cmds.push_back(mk_cmd(OP_SET_CHAR, 4'd5, "G", 8'h00));
    pending_cmds.push_back(mk_cmd(OP_SET_CHAR, 4'd6, 8'hff, 8'h00));
    pending_cmds.push_back(mk_cmd(OP_SET_CHAR, 4'd12, "8", 8'h00));
    pending_cmds.push_back(mk_cmd(OP_SET_CHAR, 4'd15, "1", 8'h00));
    pending_cmds.push_back(mk_cmd(OP_SET_RAW, 4'd7, 8'h00, 8'hff));
    pending_cmds.push_back(mk_cmd(OP_SET_RAW, 4'd9, 8'h00, 8'h55));
    pending_cmds.push_back(mk_cmd(OP_SET_RAW, 4'd4, 8'hff, 8'h00));
    pending_cmds.push_back(mk_cmd(OP_SET_RAW, 4'd14, 8'h00, 8'h7f));
    pending_cmds.push_back(mk_cmd(OP_FLUSH, 4'd0, 8'h00, 8'h00));
    pending_cmds.push_back(mk_cmd(3'd5, 4'd0, "0", 8'hff));
    pending_cmds.push_back(mk_cmd(3'd6, 4'd15, 8'hff, 8'hff));
    pending_cmds.push_back(mk_cmd(3'd7, 4'd2, "5", 8'h00));
    pending_cmds.push_back(mk_cmd(OP_CLEAR, 4'd0, 8'h00, 8'h00));
    pending_cmds.push_back(mk_cmd(OP_FLUSH, 4'd0, 8'h00, 8'h00));
    wait_idle();

    // Random phases, each under its own register setting; the spare indexes
    // get junk writes that must leave both registers alone.
    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_BRIGHTNESS, BRIGHT_SET[p]);
      write_reg(REG_ENABLE, ENABLE_SET[p]);
      write_reg((p % 2 == 0) ? REG_SPARE_A : REG_SPARE_B, 3'($urandom_range(0, 7)));
      pending_cmds.push_back(mk_cmd(OP_DISPLAY_CTL, 4'd0, 8'h00, 8'h00));
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("seven_segment_frame_driver test passed");
    end else begin
      $display("seven_segment_frame_driver test failed");
    end
    $finish;
  end

endmodule
